[src/cfptq_pkg.sv]
// ----------------------------------------------------------------------------
// CAN frame paced transmit queue package
// Shared types, codes and default sizes of the paced transmit queue.
// ----------------------------------------------------------------------------
package cfptq_pkg;

   localparam int CHANNELS_DEF   = 4;
   localparam int RING_DEPTH_DEF = 8;

   localparam int CH_FIELD_W  = 3;
   localparam int ID_W        = 29;
   localparam int LEN_W       = 4;
   localparam int PAYLOAD_W   = 64;
   localparam int MASK_W      = 8;
   localparam int TIMER_W     = 8;
   localparam int FRAME_W     = LEN_W + ID_W + PAYLOAD_W;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic       CSR_IDX_TX_GAP = 1'b0;
   localparam logic [7:0] TX_GAP_RST     = 8'd10;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [CH_FIELD_W-1:0] channel;
      logic [ID_W-1:0]       frame_id;
      logic [LEN_W-1:0]      frame_len;
      logic [PAYLOAD_W-1:0]  frame_payload;
      logic [MASK_W-1:0]     ready_mask;
   } req_type;

   typedef struct packed {
      logic                  kind;
      logic [CH_FIELD_W-1:0] out_channel;
      logic                  ok;
      logic [ID_W-1:0]       sent_id;
      logic [LEN_W-1:0]      sent_len;
      logic [PAYLOAD_W-1:0]  sent_payload;
      logic                  last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CTRL_RD,
      ST_EVAL,
      ST_FETCH
   } seq_state_type;

endpackage

[src/cfptq_ram.sv]
// ----------------------------------------------------------------------------
// Paced transmit queue RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cfptq_ram
   import cfptq_pkg::*;
#(
   parameter int DEPTH = CHANNELS_DEF,
   parameter int WIDTH = FRAME_W
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cfptq_seq.sv]
// ----------------------------------------------------------------------------
// Paced transmit queue sequencer
// Reads, updates and writes back per-channel ring state and frame slots.
// ----------------------------------------------------------------------------
module cfptq_seq
   import cfptq_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic [TIMER_W-1:0] tx_gap
);

   localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int SLOTS  = CHANNELS * RING_DEPTH;
   localparam int FA_W   = $clog2(SLOTS);
   localparam int CTRL_W = 1 + 2 * SLOT_W + TIMER_W;

   localparam logic [SLOT_W-1:0]     SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
   localparam logic [CH_AW-1:0]      CH_LAST   = CH_AW'(CHANNELS - 1);
   localparam logic [CH_FIELD_W:0]   CH_COUNT  = (CH_FIELD_W + 1)'(CHANNELS);
   localparam logic [FA_W-1:0]       DEPTH_FA  = FA_W'(RING_DEPTH);

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == SLOT_LAST) ? '0 : s + 1'b1;
   endfunction

   seq_state_type        state_ff, state_in;
   req_type              req_ff, req_in;
   logic [CH_AW-1:0]     chan_ff, chan_in;
   logic [CHANNELS-1:0]  ctrl_vld_ff, ctrl_vld_in;
   logic                 ctrl_hit_ff, ctrl_hit_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 ctrl_wr_en, ctrl_rd_en;
   logic [CTRL_W-1:0]    ctrl_wdata, ctrl_rdata;
   logic                 frame_wr_en, frame_rd_en;
   logic [FA_W-1:0]      frame_wr_addr, frame_rd_addr;
   logic [FRAME_W-1:0]   frame_wdata, frame_rdata;

   logic                 in_range, out_free, chan_is_last;
   logic                 cur_occ;
   logic [SLOT_W-1:0]    cur_head, cur_tail, tail_next;
   logic [TIMER_W-1:0]   cur_timer, timer_inc;
   logic                 enq_ok, send;
   logic [SLOT_W-1:0]    enq_slot;
   logic                 nxt_occ;
   logic [SLOT_W-1:0]    nxt_head, nxt_tail;
   logic [TIMER_W-1:0]   nxt_timer;
   logic [FA_W-1:0]      fa_base;

   cfptq_ram #(.DEPTH(CHANNELS), .WIDTH(CTRL_W)) u_ctrl_ram (
      .clock   (clock),
      .wr_en   (ctrl_wr_en),
      .wr_addr (chan_ff),
      .wr_data (ctrl_wdata),
      .rd_en   (ctrl_rd_en),
      .rd_addr (chan_ff),
      .rd_data (ctrl_rdata)
   );

   cfptq_ram #(.DEPTH(SLOTS), .WIDTH(FRAME_W)) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_wr_en),
      .wr_addr (frame_wr_addr),
      .wr_data (frame_wdata),
      .rd_en   (frame_rd_en),
      .rd_addr (frame_rd_addr),
      .rd_data (frame_rdata)
   );

   // ring state of the current channel and the update it needs
   always_comb begin
      in_range     = (req_ff.cmd == CMD_TICK) ||
                     ({1'b0, req_ff.channel} < CH_COUNT);
      out_free     = !rsp_valid_ff || !rsp_stall;
      chan_is_last = (chan_ff == CH_LAST);
      cur_occ      = ctrl_hit_ff & ctrl_rdata[CTRL_W-1];
      cur_head     = ctrl_hit_ff ? ctrl_rdata[CTRL_W-2 -: SLOT_W] : '0;
      cur_tail     = ctrl_hit_ff ? ctrl_rdata[TIMER_W +: SLOT_W] : '0;
      cur_timer    = ctrl_hit_ff ? ctrl_rdata[TIMER_W-1:0] : '0;
      tail_next    = next_slot(cur_tail);
      timer_inc    = cur_timer + 1'b1;
      enq_ok       = in_range && (!cur_occ || (tail_next != cur_head));
      enq_slot     = cur_occ ? tail_next : '0;
      send         = cur_occ && (timer_inc >= tx_gap) &&
                     req_ff.ready_mask[CH_FIELD_W'(chan_ff)];
      fa_base      = FA_W'(chan_ff) * DEPTH_FA;
      nxt_occ      = cur_occ;
      nxt_head     = cur_head;
      nxt_tail     = cur_tail;
      nxt_timer    = cur_timer;
      if (req_ff.cmd == CMD_ENQUEUE) begin
         nxt_occ  = 1'b1;
         nxt_head = cur_occ ? cur_head : '0;
         nxt_tail = enq_slot;
      end else if (send) begin
         nxt_timer = '0;
         if (cur_head == cur_tail) begin
            nxt_occ = 1'b0;
         end else begin
            nxt_head = next_slot(cur_head);
         end
      end else begin
         nxt_timer = timer_inc;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CTRL_RD;
            end
         end
         ST_CTRL_RD: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (out_free) begin
               priority if (req_ff.cmd == CMD_ENQUEUE) begin
                  state_in = ST_IDLE;
               end else if (send) begin
                  state_in = ST_FETCH;
               end else if (chan_is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CTRL_RD;
               end
            end
         end
         ST_FETCH: begin
            if (out_free) begin
               state_in = chan_is_last ? ST_IDLE : ST_CTRL_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in        = req_ff;
      chan_in       = chan_ff;
      ctrl_hit_in   = ctrl_hit_ff;
      ctrl_vld_in   = ctrl_vld_ff;
      ctrl_rd_en    = 1'b0;
      ctrl_wr_en    = 1'b0;
      ctrl_wdata    = {nxt_occ, nxt_head, nxt_tail, nxt_timer};
      frame_wr_en   = 1'b0;
      frame_wr_addr = fa_base + FA_W'(enq_slot);
      frame_wdata   = {req_ff.frame_len, req_ff.frame_id, req_ff.frame_payload};
      frame_rd_en   = 1'b0;
      frame_rd_addr = fa_base + FA_W'(cur_head);
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               chan_in = (req_data.cmd == CMD_TICK) ? '0 : CH_AW'(req_data.channel);
            end
         end
         ST_CTRL_RD: begin
            ctrl_rd_en  = in_range;
            ctrl_hit_in = in_range && ctrl_vld_ff[chan_ff];
         end
         ST_EVAL: begin
            if (out_free) begin
               if (req_ff.cmd == CMD_ENQUEUE) begin
                  ctrl_wr_en   = enq_ok;
                  frame_wr_en  = enq_ok;
                  if (enq_ok) begin
                     ctrl_vld_in[chan_ff] = 1'b1;
                  end
                  rsp_in       = '{kind: KIND_ENQUEUE, out_channel: req_ff.channel,
                                   ok: enq_ok, sent_id: '0, sent_len: '0,
                                   sent_payload: '0, last: 1'b1};
                  rsp_valid_in = 1'b1;
               end else begin
                  ctrl_wr_en           = 1'b1;
                  ctrl_vld_in[chan_ff] = 1'b1;
                  frame_rd_en          = send;
                  if (!send) begin
                     rsp_in       = '{kind: KIND_TICK, out_channel: CH_FIELD_W'(chan_ff),
                                      ok: 1'b0, sent_id: '0, sent_len: '0,
                                      sent_payload: '0, last: chan_is_last};
                     rsp_valid_in = 1'b1;
                     chan_in      = chan_ff + 1'b1;
                  end
               end
            end
         end
         ST_FETCH: begin
            if (out_free) begin
               rsp_in       = '{kind: KIND_TICK, out_channel: CH_FIELD_W'(chan_ff),
                                ok: 1'b1,
                                sent_id: frame_rdata[PAYLOAD_W +: ID_W],
                                sent_len: frame_rdata[FRAME_W-1 -: LEN_W],
                                sent_payload: frame_rdata[PAYLOAD_W-1:0],
                                last: chan_is_last};
               rsp_valid_in = 1'b1;
               chan_in      = chan_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctrl_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctrl_vld_ff  <= ctrl_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      chan_ff     <= chan_in;
      ctrl_hit_ff <= ctrl_hit_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/can_frame_paced_transmit_queue.sv]
// ----------------------------------------------------------------------------
// CAN frame paced transmit queue
// Per-channel frame rings with an interval timer that paces transmission.
// ----------------------------------------------------------------------------
// An enqueue item is taken, then the channel's ring state is read from the
// control RAM, then the frame and the updated state are written back; its
// result is registered in the write-back step. A tick item walks the channels
// one after another; each channel costs a control RAM read, then an update
// and write back, plus a frame RAM read when a frame goes out. The result
// register lets a finished result wait while the walk reads the next channel;
// a stall on the result side holds the walk at an update or fetch step for as
// long as the previous result still waits. No clearing pass is needed after
// reset.
module can_frame_paced_transmit_queue
   import cfptq_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [TIMER_W-1:0] tx_gap_ff, tx_gap_in;
   logic               csr_wr;

   always_comb begin
      csr_wr    = csr_psel && csr_penable && csr_pwrite;
      tx_gap_in = tx_gap_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_TX_GAP)) begin
         tx_gap_in = csr_pwdata[TIMER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_gap_ff <= TX_GAP_RST;
      end else begin
         tx_gap_ff <= tx_gap_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_TX_GAP) begin
         csr_prdata = {{(CSR_DATA_W - TIMER_W){1'b0}}, tx_gap_ff};
      end
   end

   assign csr_pready = 1'b1;

   cfptq_seq #(.CHANNELS(CHANNELS), .RING_DEPTH(RING_DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .tx_gap    (tx_gap_ff)
   );

endmodule

[src/cfptq_checker.sv]
// ----------------------------------------------------------------------------
// CAN frame paced transmit queue checker
// Port-level checks of the paced transmit queue, bound to the top level.
// ----------------------------------------------------------------------------
module cfptq_checker
   import cfptq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item taken while another is in work");

   a_no_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.kind == KIND_ENQUEUE) || !rsp_data.ok) |->
         (rsp_data.sent_id == '0) && (rsp_data.sent_len == '0) &&
         (rsp_data.sent_payload == '0))
      else $error("frame fields set on a result without a sent frame");

endmodule

bind can_frame_paced_transmit_queue cfptq_checker u_cfptq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
